FILE: rtl/core/tvsq_pkg.sv
// Shared types, codes and level table of the two-voice square and noise sound generator.
package tvsq_pkg;

  // Command codes carried in the func field.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_V0_LO   = 3'd0;
  localparam logic [2:0] REG_V1_LO   = 3'd1;
  localparam logic [2:0] REG_V1_HI   = 3'd2;
  localparam logic [2:0] REG_CONTROL = 3'd3;
  localparam logic [2:0] REG_V0_HI   = 3'd4;

  localparam int unsigned FREQ_W  = 10;
  localparam int unsigned LEVEL_W = 15;

  localparam logic [FREQ_W-1:0] HOLD_FREQ   = 10'h3fe;
  localparam logic [FREQ_W-1:0] HALT_RELOAD = 10'h3ff;
  localparam logic [FREQ_W-1:0] COUNT_TOP   = 10'h3ff;
  localparam logic [7:0]        V1_HI_FILL  = 8'h7c;
  localparam logic [7:0]        LFSR_SEED   = 8'hff;

  // Command item and result item.
  typedef struct packed {
    logic [1:0] func;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } tvsq_cmd_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic [LEVEL_W-1:0] level;
  } tvsq_res_t;

  // Level for one active voice (or noise) by volume 0 to 7; level_lookup saturates volumes 8 and up.
  function automatic logic [LEVEL_W-1:0] level_one(input logic [2:0] vol);
    logic [LEVEL_W-1:0] lv;
    case (vol)
      3'd0: lv = 15'h0000;
      3'd1: lv = 15'h0299;
      3'd2: lv = 15'h076b;
      3'd3: lv = 15'h0c31;
      3'd4: lv = 15'h1111;
      3'd5: lv = 15'h1603;
      3'd6: lv = 15'h1afb;
      3'd7: lv = 15'h2009;
      default: lv = 15'h0000;
    endcase
    return lv;
  endfunction

  // Level with both channels active.
  function automatic logic [LEVEL_W-1:0] level_both(input logic [2:0] vol);
    logic [LEVEL_W-1:0] lv;
    case (vol)
      3'd0: lv = 15'h0000;
      3'd1: lv = 15'h0558;
      3'd2: lv = 15'h0f19;
      3'd3: lv = 15'h18e7;
      3'd4: lv = 15'h2323;
      3'd5: lv = 15'h2d96;
      3'd6: lv = 15'h3861;
      3'd7: lv = 15'h43c1;
      default: lv = 15'h0000;
    endcase
    return lv;
  endfunction

  // Output level for the index {channel 1 on, channel 0 on, volume}.
  function automatic logic [LEVEL_W-1:0] level_lookup(input logic [5:0] idx);
    logic [LEVEL_W-1:0] lv;
    case (idx[5:4])
      2'b00: lv = 15'h0000;
      2'b01, 2'b10: lv = idx[3] ? 15'h2461 : level_one(idx[2:0]);
      2'b11: lv = idx[3] ? 15'h4e08 : level_both(idx[2:0]);
      default: lv = 15'h0000;
    endcase
    return lv;
  endfunction

endpackage

FILE: rtl/core/two_voice_square_noise_sound.sv
// Top level of the two-voice square-wave sound generator with a noise source.
//
//   Channel | Direction | Handshake            | Payload
//   cmd     | in        | cmd_valid, cmd_stall | tvsq_cmd_t: func, reg_index, write_data
//   res     | out       | res_valid, res_stall | tvsq_res_t: read_data, level
//
// Each command yields exactly one result: the command is held in the command register,
// then the engine updates state and fills the result register. One command a cycle
// is sustained while the result side does not stall.
// Reset (rst, synchronous) empties both registers and returns all sound state to its
// power-up values. A stall on the result side holds the result; the command register
// still drains into a free result register, so cmd_stall only rises when both are full.
module two_voice_square_noise_sound (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  tvsq_pkg::tvsq_cmd_t cmd,
  output logic                res_valid,
  input  logic                res_stall,
  output tvsq_pkg::tvsq_res_t res
);

  // Command register: holds one accepted command until the engine takes it.
  logic                cmd_full;
  tvsq_pkg::tvsq_cmd_t cmd_q;
  tvsq_pkg::tvsq_res_t res_calc;
  logic                advance;

  // The engine runs whenever a command is waiting and the result register can take its result.
  assign advance   = cmd_full & (~res_valid | ~res_stall);
  assign cmd_stall = cmd_full & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_full <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      cmd_full <= 1'b1;
    end else if (advance) begin
      cmd_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_q <= cmd;
    end
  end

  tvsq_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .cmd  (cmd_q),
    .res  (res_calc)
  );

  // Result register: a stalled result stays put until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_calc;
    end
  end

endmodule

FILE: rtl/core/tvsq_engine.sv
// Register file, voice counters, noise shifter and level lookup for one command per cycle while fire is high.
module tvsq_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  tvsq_pkg::tvsq_cmd_t cmd,
  output tvsq_pkg::tvsq_res_t res
);

  logic [7:0] v0_lo, v1_lo, control;
  logic [1:0] v0_hi, v1_hi;
  logic [9:0] v0_count, v1_count;
  logic       v0_phase, v1_phase, noise_bit;
  logic [7:0] lfsr;

  logic [7:0] v0_lo_next, v1_lo_next, control_next;
  logic [1:0] v0_hi_next, v1_hi_next;
  logic [9:0] v0_count_next, v1_count_next;
  logic       v0_phase_next, v1_phase_next, noise_bit_next;
  logic [7:0] lfsr_next;

  logic [9:0] reload0, reload1;
  logic [7:0] read_value;
  logic [5:0] level_idx;
  logic       ch0_on, ch1_on;

  assign reload0 = {v0_hi, v0_lo} + 10'd1;
  assign reload1 = {v1_hi, v1_lo} + 10'd1;

  always_comb begin
    v0_lo_next     = v0_lo;
    v0_hi_next     = v0_hi;
    v1_lo_next     = v1_lo;
    v1_hi_next     = v1_hi;
    control_next   = control;
    v0_count_next  = v0_count;
    v1_count_next  = v1_count;
    v0_phase_next  = v0_phase;
    v1_phase_next  = v1_phase;
    noise_bit_next = noise_bit;
    lfsr_next      = lfsr;
    read_value     = 8'h00;
    case (cmd.func)
      tvsq_pkg::FUNC_WRITE: begin
        case (cmd.reg_index)
          tvsq_pkg::REG_V0_LO: begin
            v0_lo_next = cmd.write_data;
            if ({v0_hi, cmd.write_data} == tvsq_pkg::HOLD_FREQ) v0_phase_next = 1'b1;
          end
          tvsq_pkg::REG_V0_HI: begin
            v0_hi_next = cmd.write_data[1:0];
            if ({cmd.write_data[1:0], v0_lo} == tvsq_pkg::HOLD_FREQ) v0_phase_next = 1'b1;
          end
          tvsq_pkg::REG_V1_LO: begin
            v1_lo_next = cmd.write_data;
            if ({v1_hi, cmd.write_data} == tvsq_pkg::HOLD_FREQ) v1_phase_next = 1'b1;
          end
          tvsq_pkg::REG_V1_HI: begin
            v1_hi_next = cmd.write_data[1:0];
            if ({cmd.write_data[1:0], v1_lo} == tvsq_pkg::HOLD_FREQ) v1_phase_next = 1'b1;
          end
          tvsq_pkg::REG_CONTROL: begin
            control_next = cmd.write_data;
            if (cmd.write_data[7]) begin
              v0_phase_next  = 1'b1;
              v1_phase_next  = 1'b1;
              lfsr_next      = tvsq_pkg::LFSR_SEED;
              noise_bit_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      tvsq_pkg::FUNC_READ: begin
        case (cmd.reg_index)
          tvsq_pkg::REG_V0_LO:   read_value = v0_lo;
          tvsq_pkg::REG_V1_LO:   read_value = v1_lo;
          tvsq_pkg::REG_V1_HI:   read_value = tvsq_pkg::V1_HI_FILL | {6'd0, v1_hi};
          tvsq_pkg::REG_CONTROL: read_value = control;
          tvsq_pkg::REG_V0_HI:   read_value = {6'd0, v0_hi};
          default:               read_value = 8'h00;
        endcase
      end
      tvsq_pkg::FUNC_TICK: begin
        if (control[7]) begin
          // Digital mode parks both counters at their reload values.
          v0_count_next = reload0;
          v1_count_next = reload1;
        end else begin
          if (reload0 != tvsq_pkg::HALT_RELOAD) begin
            if (v0_count == tvsq_pkg::COUNT_TOP) begin
              v0_phase_next = ~v0_phase;
              v0_count_next = reload0;
            end else begin
              v0_count_next = v0_count + 10'd1;
            end
          end
          if (reload1 != tvsq_pkg::HALT_RELOAD) begin
            if (v1_count == tvsq_pkg::COUNT_TOP) begin
              v1_phase_next  = ~v1_phase;
              v1_count_next  = reload1;
              noise_bit_next = lfsr[0];
              lfsr_next      = {lfsr[6:0], lfsr[7] ^ lfsr[5] ^ lfsr[4] ^ lfsr[1]};
            end else begin
              v1_count_next = v1_count + 10'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // The level reflects the state after this command.
  assign ch0_on = v0_phase_next & control_next[4];
  assign ch1_on = (v1_phase_next & control_next[5]) |
                  (noise_bit_next & (control_next[6:5] == 2'b10));
  assign level_idx = control_next[7] ? control_next[5:0] : {ch1_on, ch0_on, control_next[3:0]};

  assign res.read_data = read_value;
  assign res.level     = tvsq_pkg::level_lookup(level_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0_lo     <= 8'h00;
      v0_hi     <= 2'b00;
      v1_lo     <= 8'h00;
      v1_hi     <= 2'b00;
      control   <= 8'h00;
      v0_count  <= 10'd0;
      v1_count  <= 10'd0;
      v0_phase  <= 1'b0;
      v1_phase  <= 1'b0;
      lfsr      <= tvsq_pkg::LFSR_SEED;
      noise_bit <= 1'b1;
    end else if (fire) begin
      v0_lo     <= v0_lo_next;
      v0_hi     <= v0_hi_next;
      v1_lo     <= v1_lo_next;
      v1_hi     <= v1_hi_next;
      control   <= control_next;
      v0_count  <= v0_count_next;
      v1_count  <= v1_count_next;
      v0_phase  <= v0_phase_next;
      v1_phase  <= v1_phase_next;
      lfsr      <= lfsr_next;
      noise_bit <= noise_bit_next;
    end
  end

endmodule

FILE: rtl/core/tvsq_checker.sv
// Port-level checks of the sound generator and their binding to the top level.
module tvsq_props (
  input logic                clk,
  input logic                rst,
  input logic                cmd_stall,
  input logic                res_valid,
  input logic                res_stall,
  input tvsq_pkg::tvsq_res_t res
);

  // Reset leaves the block empty and ready for a command.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid && !cmd_stall)
    else $error("block not empty after reset");

  // Commands are only held back while a result waits on a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (!res_valid || !res_stall) |-> !cmd_stall)
    else $error("command stalled with a free result side");

  // A stalled result holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // No level exceeds the top table entry.
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.level <= 15'h4e08)
    else $error("level beyond table range");

endmodule

bind two_voice_square_noise_sound tvsq_props u_tvsq_props (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

FILE: tb/sv/tvsq_checker.sv
`timescale 1ns / 1ps
// Checker that tracks the sound generator state and compares every result transfer.
module tvsq_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_stall,
  input  tvsq_pkg::tvsq_cmd_t cmd,
  input  logic                res_valid,
  input  logic                res_stall,
  input  tvsq_pkg::tvsq_res_t res,
  output int unsigned         mismatches,
  output int unsigned         outstanding
);

  // Levels by volume for one active channel and for both, highest volume first.
  localparam logic [7:0][tvsq_pkg::LEVEL_W-1:0] ONE_ON_LEVELS = {
    15'h2009, 15'h1afb, 15'h1603, 15'h1111, 15'h0c31, 15'h076b, 15'h0299, 15'h0000
  };
  localparam logic [7:0][tvsq_pkg::LEVEL_W-1:0] BOTH_ON_LEVELS = {
    15'h43c1, 15'h3861, 15'h2d96, 15'h2323, 15'h18e7, 15'h0f19, 15'h0558, 15'h0000
  };
  localparam logic [tvsq_pkg::LEVEL_W-1:0] ONE_ON_FULL  = 15'h2461;
  localparam logic [tvsq_pkg::LEVEL_W-1:0] BOTH_ON_FULL = 15'h4e08;

  // Mirror of the generator state.
  logic [7:0]                  v0_lo, v1_lo, ctrl_reg, lfsr;
  logic [1:0]                  v0_hi, v1_hi;
  logic [tvsq_pkg::FREQ_W-1:0] v0_cnt, v1_cnt;
  logic                        v0_sq, v1_sq, noise_out;

  tvsq_pkg::tvsq_res_t expected_q[$];
  tvsq_pkg::tvsq_res_t want, fresh;
  int unsigned         bad;

  function automatic logic [tvsq_pkg::LEVEL_W-1:0] level_for(input logic [5:0] idx);
    if (idx[5:4] == 2'b00) return '0;
    if (idx[5:4] == 2'b11) return idx[3] ? BOTH_ON_FULL : BOTH_ON_LEVELS[idx[2:0]];
    return idx[3] ? ONE_ON_FULL : ONE_ON_LEVELS[idx[2:0]];
  endfunction

  // Applies one command to the mirror and returns the result it should produce.
  task automatic step_sound(input tvsq_pkg::tvsq_cmd_t c, output tvsq_pkg::tvsq_res_t r);
    logic [tvsq_pkg::FREQ_W-1:0] rl0, rl1;
    logic [5:0]                  idx;
    rl0 = {v0_hi, v0_lo} + 1'b1;
    rl1 = {v1_hi, v1_lo} + 1'b1;
    r = '0;
    case (c.func)
      tvsq_pkg::FUNC_WRITE: begin
        case (c.reg_index)
          tvsq_pkg::REG_V0_LO: begin
            v0_lo = c.write_data;
            if ({v0_hi, v0_lo} == tvsq_pkg::HOLD_FREQ) v0_sq = 1'b1;
          end
          tvsq_pkg::REG_V0_HI: begin
            v0_hi = c.write_data[1:0];
            if ({v0_hi, v0_lo} == tvsq_pkg::HOLD_FREQ) v0_sq = 1'b1;
          end
          tvsq_pkg::REG_V1_LO: begin
            v1_lo = c.write_data;
            if ({v1_hi, v1_lo} == tvsq_pkg::HOLD_FREQ) v1_sq = 1'b1;
          end
          tvsq_pkg::REG_V1_HI: begin
            v1_hi = c.write_data[1:0];
            if ({v1_hi, v1_lo} == tvsq_pkg::HOLD_FREQ) v1_sq = 1'b1;
          end
          tvsq_pkg::REG_CONTROL: begin
            ctrl_reg = c.write_data;
            // Entering digital mode, even again, forces the phases and reseeds the noise.
            if (c.write_data[7]) begin
              v0_sq = 1'b1;
              v1_sq = 1'b1;
              lfsr = tvsq_pkg::LFSR_SEED;
              noise_out = 1'b1;
            end
          end
          default: ;
        endcase
      end
      tvsq_pkg::FUNC_READ: begin
        case (c.reg_index)
          tvsq_pkg::REG_V0_LO:   r.read_data = v0_lo;
          tvsq_pkg::REG_V1_LO:   r.read_data = v1_lo;
          tvsq_pkg::REG_V1_HI:   r.read_data = tvsq_pkg::V1_HI_FILL | {6'd0, v1_hi};
          tvsq_pkg::REG_CONTROL: r.read_data = ctrl_reg;
          tvsq_pkg::REG_V0_HI:   r.read_data = {6'd0, v0_hi};
          default:               r.read_data = '0;
        endcase
      end
      tvsq_pkg::FUNC_TICK: begin
        if (ctrl_reg[7]) begin
          v0_cnt = rl0;
          v1_cnt = rl1;
        end else begin
          if (rl0 != tvsq_pkg::HALT_RELOAD) begin
            if (v0_cnt == tvsq_pkg::COUNT_TOP) begin
              v0_sq = ~v0_sq;
              v0_cnt = rl0;
            end else begin
              v0_cnt = v0_cnt + 1'b1;
            end
          end
          if (rl1 != tvsq_pkg::HALT_RELOAD) begin
            if (v1_cnt == tvsq_pkg::COUNT_TOP) begin
              v1_sq = ~v1_sq;
              v1_cnt = rl1;
              noise_out = lfsr[0];
              lfsr = {lfsr[6:0], lfsr[7] ^ lfsr[5] ^ lfsr[4] ^ lfsr[1]};
            end else begin
              v1_cnt = v1_cnt + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    if (ctrl_reg[7]) begin
      idx = ctrl_reg[5:0];
    end else begin
      idx = {(v1_sq & ctrl_reg[5]) | (noise_out & (ctrl_reg[6:5] == 2'b10)),
             v0_sq & ctrl_reg[4], ctrl_reg[3:0]};
    end
    r.level = level_for(idx);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      v0_lo = '0;
      v0_hi = '0;
      v1_lo = '0;
      v1_hi = '0;
      ctrl_reg = '0;
      v0_cnt = '0;
      v1_cnt = '0;
      v0_sq = 1'b0;
      v1_sq = 1'b0;
      lfsr = tvsq_pkg::LFSR_SEED;
      noise_out = 1'b1;
      expected_q.delete();
      mismatches <= 0;
      outstanding <= 0;
    end else begin
      bad = 0;
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, got read_data %02h level %04h",
                   $time, res.read_data, res.level);
          bad++;
        end else begin
          want = expected_q.pop_front();
          if (res.read_data !== want.read_data) begin
            $display("%0t: read_data expected %02h, got %02h", $time, want.read_data,
                     res.read_data);
            bad++;
          end
          if (res.level !== want.level) begin
            $display("%0t: level expected %04h, got %04h", $time, want.level, res.level);
            bad++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        step_sound(cmd, fresh);
        expected_q.push_back(fresh);
      end
      mismatches <= mismatches + bad;
      outstanding <= expected_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, command stimulus, result stalls and the verdict.
module tb_top;

  // Codes the block has no meaning for; it must leave its state alone on them.
  localparam logic [1:0] FUNC_NONE    = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Control byte fields.
  localparam logic [7:0] CTRL_DIGITAL = 8'h80;
  localparam logic [7:0] CTRL_NOISE   = 8'h40;
  localparam logic [7:0] CTRL_V1_ON   = 8'h20;
  localparam logic [7:0] CTRL_V0_ON   = 8'h10;
  localparam logic [7:0] VOL_MAX      = 8'h0f;

  localparam int unsigned RANDOM_ITEMS   = 1550;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  tvsq_pkg::tvsq_cmd_t cmd = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  tvsq_pkg::tvsq_res_t res;

  int unsigned mismatches, outstanding;
  int unsigned idle_pct = 0;      // chance in percent that the sender sits out a cycle
  int unsigned stall_pct = 0;     // chance in percent that the receiver stalls a cycle
  int unsigned hold_gen = 0;      // bumping this asks the receiver for a long hold-off
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent = 0;
  int unsigned random_base;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  two_voice_square_noise_sound u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  tvsq_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Result side. A long hold-off, once requested, overrides the random stalls;
  // the count lives here so the sender never has to time it.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_gen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: any transfer on either channel counts as progress. A long run of
  // cycles without one means the block has hung or lost a result.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one command and returns at the edge where its transfer happens. Valid
  // only drops when the sender decides to idle, so back-to-back commands keep it
  // high without a low/high pair in the same step.
  task automatic send_cmd(input logic [1:0] func, input logic [2:0] idx,
                          input logic [7:0] data);
    if ($urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    cmd <= '{func: func, reg_index: idx, write_data: data};
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    sent++;
  endtask

  // Stops offering and waits until every expected result has been transferred.
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Frequencies mostly sit near the top so that the counters wrap often and the
  // hold and slowest-rate values come up regularly.
  function automatic logic [tvsq_pkg::FREQ_W-1:0] pick_freq();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 10'h3f0 + 10'($urandom_range(0, 15));
    if (r < 8) return 10'($urandom_range(10'h3c0, 10'h3ff));
    return 10'($urandom);
  endfunction

  // One well-formed sequence: program both voices and the control byte, then run
  // a burst that is mostly ticks, mixed with reads, stray writes and junk commands.
  task automatic run_segment();
    logic [tvsq_pkg::FREQ_W-1:0] f0, f1;
    logic [5:0]                  pad;
    logic [7:0]                  ctl;
    int unsigned                 n, r;
    f0 = pick_freq();
    f1 = pick_freq();
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_V0_LO, f0[7:0]);
    pad = 6'($urandom);
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_V0_HI, {pad, f0[9:8]});
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_V1_LO, f1[7:0]);
    pad = 6'($urandom);
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_V1_HI, {pad, f1[9:8]});
    ctl = 8'($urandom);
    if ($urandom_range(0, 9) != 0) ctl[7] = 1'b0;
    if ($urandom_range(0, 9) < 4) ctl[6:5] = 2'b10;
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_CONTROL, ctl);
    n = $urandom_range(8, 40);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_cmd(tvsq_pkg::FUNC_TICK, 3'($urandom), 8'($urandom));
      end else if (r < 80) begin
        send_cmd(tvsq_pkg::FUNC_READ, 3'($urandom_range(0, 4)), 8'($urandom));
      end else if (r < 93) begin
        send_cmd(tvsq_pkg::FUNC_WRITE, 3'($urandom_range(0, 4)), 8'($urandom));
      end else if ($urandom_range(0, 1) == 1) begin
        send_cmd(FUNC_NONE, 3'($urandom), 8'($urandom));
      end else begin
        send_cmd(($urandom_range(0, 1) == 1) ? tvsq_pkg::FUNC_WRITE : tvsq_pkg::FUNC_READ,
                 3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Every register right after reset, plus an index that does not exist.
    send_cmd(tvsq_pkg::FUNC_READ, tvsq_pkg::REG_V0_LO, 8'h00);
    send_cmd(tvsq_pkg::FUNC_READ, tvsq_pkg::REG_V1_LO, 8'h00);
    send_cmd(tvsq_pkg::FUNC_READ, tvsq_pkg::REG_V1_HI, 8'h00);
    send_cmd(tvsq_pkg::FUNC_READ, tvsq_pkg::REG_CONTROL, 8'h00);
    send_cmd(tvsq_pkg::FUNC_READ, tvsq_pkg::REG_V0_HI, 8'h00);
    send_cmd(tvsq_pkg::FUNC_READ, REG_SPARE_HI, 8'hff);
    // Voice 0 gets the hold frequency; the high write also carries junk upper bits.
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_V0_LO, 8'hfe);
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_V0_HI, 8'hff);
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_CONTROL, CTRL_V0_ON | VOL_MAX);
    send_cmd(tvsq_pkg::FUNC_TICK, tvsq_pkg::REG_V0_LO, 8'h00);
    // Voice 1 just under the hold value, so it toggles every other tick once loaded.
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_V1_LO, 8'hfd);
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_V1_HI, 8'h03);
    // Digital mode: a tick only reloads the counters. Writing it again while
    // already in digital mode reseeds the noise once more.
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_CONTROL,
             CTRL_DIGITAL | CTRL_V1_ON | CTRL_V0_ON | VOL_MAX);
    send_cmd(tvsq_pkg::FUNC_TICK, tvsq_pkg::REG_V0_LO, 8'h00);
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_CONTROL, CTRL_DIGITAL | CTRL_NOISE | 8'h08);
    // Noise mode with voice 0 on: the noise bit reaches the level as voice 1 wraps.
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_CONTROL, CTRL_NOISE | CTRL_V0_ON | 8'h07);
    repeat (4) send_cmd(tvsq_pkg::FUNC_TICK, tvsq_pkg::REG_V0_LO, 8'h00);
    send_cmd(tvsq_pkg::FUNC_WRITE, REG_SPARE_LO, 8'haa);
    send_cmd(FUNC_NONE, tvsq_pkg::REG_CONTROL, 8'h55);
    send_cmd(tvsq_pkg::FUNC_READ, tvsq_pkg::REG_V1_HI, 8'h00);
    // Frequency 0x3ff reloads to zero: the slowest rate.
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_V0_LO, 8'hff);
    send_cmd(tvsq_pkg::FUNC_WRITE, tvsq_pkg::REG_CONTROL, 8'h00);

    // Long hold-off on the result side while ticks keep coming, so both internal
    // registers fill and cmd_stall rises; then a full drain before going on.
    hold_gen <= hold_gen + 1;
    repeat (12) send_cmd(tvsq_pkg::FUNC_TICK, tvsq_pkg::REG_V0_LO, 8'h00);
    wait_drained();

    // Random sequences. The run cycles twice through four idling phases: none,
    // sender idle half the time, receiver stalling half the time, and both at 31%.
    random_base = sent;
    while (sent - random_base < RANDOM_ITEMS) begin
      case ((sent - random_base) * 8 / RANDOM_ITEMS % 4)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 50;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 50;
        end
        default: begin
          idle_pct = 31;
          stall_pct <= 31;
        end
      endcase
      run_segment();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
